>>> hdl/icr_pkg.sv
// shared types and command codes for the interval counter history ring
// no dependencies; imported by icr_ram, icr_ctrl and interval_counter_history_ring
`default_nettype none

package icr_pkg;

  localparam int COUNT_W = 64;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUB  = 2'd1;
  localparam logic [1:0] CMD_ROLL = 2'd2;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [3:0]                key;
    logic signed [COUNT_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count_now;
    logic [2:0]                head_slot;
    logic [2:0]                tail_slot;
  } out_item_t;

endpackage

`default_nettype wire

>>> hdl/icr_ram.sv
// counter store: single-port-write, single-port-read synchronous ram
// read data registered; uses icr_pkg for the word width
`default_nettype none

module icr_ram #(
  parameter int DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [icr_pkg::COUNT_W-1:0]     rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [icr_pkg::COUNT_W-1:0] wr_data
);
  import icr_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/icr_ctrl.sv
// sequencer: reset clearing pass, read-modify-write of one counter, column clear on rollover
// depends on icr_pkg; drives the ports of icr_ram
`default_nettype none

module icr_ctrl #(
  parameter int NUM_KEYS      = 16,
  parameter int HISTORY_DEPTH = 8,
  parameter int ADDR_W        = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire icr_pkg::in_item_t           in_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output icr_pkg::out_item_t               res_data,
  output logic                             rd_en,
  output logic [ADDR_W-1:0]                rd_addr,
  input  wire logic [icr_pkg::COUNT_W-1:0] rd_data,
  output logic                             wr_en,
  output logic [ADDR_W-1:0]                wr_addr,
  output logic [icr_pkg::COUNT_W-1:0]      wr_data
);
  import icr_pkg::*;

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int DEPTH  = HISTORY_DEPTH << KEY_W;
  localparam logic [KEY_W-1:0]  LAST_KEY  = KEY_W'(NUM_KEYS - 1);
  localparam logic [HEAD_W-1:0] LAST_SLOT = HEAD_W'(HISTORY_DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [8:0]        KEY_LIMIT = 9'(NUM_KEYS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_ROLL,
    ST_RESP
  } state_t;

  state_t              state_r;
  logic [HEAD_W-1:0]   head_r;
  logic [HEAD_W-1:0]   tail_r;
  logic [ADDR_W-1:0]   sweep_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                sub_r;
  logic [COUNT_W-1:0]  value_r;

  logic                in_fire;
  logic                res_fire;
  logic [8:0]          key_wide;
  logic                key_ok;
  logic                is_arith;
  logic [HEAD_W-1:0]   head_inc;
  logic [HEAD_W-1:0]   tail_inc;
  logic [COUNT_W-1:0]  upd;
  logic [8:0]          head_wide;
  logic [8:0]          tail_wide;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign key_wide = {5'b0, in_data.key};
  assign key_ok   = key_wide < KEY_LIMIT;
  assign is_arith = (in_data.cmd == CMD_ADD) || (in_data.cmd == CMD_SUB);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;

  // read issued at the transfer, data back in ST_UPD
  assign rd_en   = in_fire;
  assign rd_addr = {head_r, key_wide[KEY_W-1:0]};

  assign upd = sub_r ? (rd_data - value_r) : (rd_data + value_r);

  assign res_valid = (state_r == ST_UPD) || (state_r == ST_RESP);
  assign res_fire  = res_valid && res_ready;

  assign head_wide = 9'(head_r);
  assign tail_wide = 9'(tail_r);

  always_comb begin
    res_data.count_now = (state_r == ST_UPD) ? upd : '0;
    res_data.head_slot = head_wide[2:0];
    res_data.tail_slot = tail_wide[2:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_r;
    wr_data = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_ROLL: begin
        wr_en   = 1'b1;
        wr_addr = {head_r, sweep_r[KEY_W-1:0]};
      end
      ST_UPD: begin
        wr_en   = res_ready;
        wr_addr = addr_r;
        wr_data = upd;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      head_r  <= '0;
      tail_r  <= '0;
      sweep_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            addr_r  <= rd_addr;
            sub_r   <= (in_data.cmd == CMD_SUB);
            value_r <= in_data.value;
            sweep_r <= '0;
            if (is_arith && key_ok) begin
              state_r <= ST_UPD;
            end else if (in_data.cmd == CMD_ROLL) begin
              head_r <= head_inc;
              if (tail_r == head_inc) begin
                tail_r <= tail_inc;
              end
              state_r <= ST_ROLL;
            end else begin
              state_r <= ST_RESP;
            end
          end
        end
        ST_UPD: begin
          if (res_fire) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ROLL: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r[KEY_W-1:0] == LAST_KEY) begin
            state_r <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (res_fire) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/interval_counter_history_ring.sv
// top level of the interval counter history ring: sequencer, counter ram, output register
// depends on icr_pkg, icr_ram and icr_ctrl
`default_nettype none

// Signed 64-bit counters, one per key, for each of HISTORY_DEPTH interval columns
// kept as a ring. cmd add or subtract updates key's counter in the head column
// (two's complement wrap) and returns the new value; rollover advances head,
// pushes tail along when head meets it, clears the new head column and returns zero.
// An unused command, or add or subtract with a key at or above NUM_KEYS, changes
// nothing and returns zero. Every result carries head and tail after the step
// (low 3 bits). All counters live in one ram with a registered read, so add/subtract
// runs as transfer plus read, then modify and write back; a rollover makes one ram
// write per key of the cleared column. After reset a clearing pass writes zero to
// every ram word (HISTORY_DEPTH << KEY_W words, 128 with the defaults, with
// KEY_W = max(1, ceil(log2(NUM_KEYS)))), and in_ready stays low meanwhile. An
// output register holds each result until its transfer.

module interval_counter_history_ring #(
  parameter int NUM_KEYS      = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire icr_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output icr_pkg::out_item_t       out_data
);
  import icr_pkg::*;

  // ram address is {column, key}, key part rounded up to a power of two
  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int DEPTH  = HISTORY_DEPTH << KEY_W;
  localparam int ADDR_W = $clog2(DEPTH);

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  icr_ctrl #(
    .NUM_KEYS      (NUM_KEYS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  icr_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // room for a new result when empty or when the held one leaves this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
